// ===== rtl/putm_pkg.sv =====
// Shared types, codes and the sequencer program for the triangular matrix unit.
package putm_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;
  localparam int unsigned STEP_W = 3;

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4
  } op_e;

  // How the sequencer picks its next step.
  typedef enum logic [1:0] {
    COND_NONE  = 2'd0,
    COND_CMD   = 2'd1,
    COND_INNER = 2'd2,
    COND_OUTER = 2'd3
  } cond_e;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RD   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ACC  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;

  typedef struct packed {
    logic              in_rdy;
    logic              rd;
    logic              mul;
    logic              acc;
    logic              emit;
    cond_e             cond;
    logic [STEP_W-1:0] jmp;
  } ctrl_t;

  typedef struct packed {
    logic cmd_go;
    logic inner_more;
    logic slot_free;
    logic last;
  } status_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(logic [STEP_W-1:0] pc);
    ctrl_t cw;
    cw = '{in_rdy: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
           cond: COND_CMD, jmp: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: cw = '{in_rdy: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
                        cond: COND_CMD, jmp: STEP_IDLE};
      STEP_RD:   cw = '{in_rdy: 1'b0, rd: 1'b1, mul: 1'b0, acc: 1'b0, emit: 1'b0,
                        cond: COND_NONE, jmp: STEP_IDLE};
      STEP_MUL:  cw = '{in_rdy: 1'b0, rd: 1'b0, mul: 1'b1, acc: 1'b0, emit: 1'b0,
                        cond: COND_NONE, jmp: STEP_IDLE};
      STEP_ACC:  cw = '{in_rdy: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b1, emit: 1'b0,
                        cond: COND_INNER, jmp: STEP_RD};
      STEP_EMIT: cw = '{in_rdy: 1'b0, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b1,
                        cond: COND_OUTER, jmp: STEP_RD};
      default:   cw = '{in_rdy: 1'b1, rd: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
                        cond: COND_CMD, jmp: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/putm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module putm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 36,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/putm_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module putm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  putm_pkg::status_t st_i,
  output putm_pkg::ctrl_t   cw_o
);

  logic [putm_pkg::STEP_W-1:0] pc_q, pc_d;
  putm_pkg::ctrl_t cw;

  assign cw = putm_pkg::ucode(pc_q);
  assign cw_o = cw;

  always_comb begin
    pc_d = pc_q + putm_pkg::STEP_W'(1);
    unique case (cw.cond)
      putm_pkg::COND_NONE:  pc_d = pc_q + putm_pkg::STEP_W'(1);
      putm_pkg::COND_CMD:   pc_d = st_i.cmd_go ? pc_q + putm_pkg::STEP_W'(1) : cw.jmp;
      putm_pkg::COND_INNER: pc_d = st_i.inner_more ? cw.jmp : pc_q + putm_pkg::STEP_W'(1);
      putm_pkg::COND_OUTER: begin
        if (!st_i.slot_free) begin
          pc_d = pc_q;
        end else if (st_i.last) begin
          pc_d = putm_pkg::STEP_IDLE;
        end else begin
          pc_d = cw.jmp;
        end
      end
      default:              pc_d = putm_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= putm_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/packed_upper_triangular_matrix_ops.sv =====
// Top level of the packed upper-triangular matrix add, subtract and multiply unit.
//
//  Channel  Direction  Handshake                   Contents
//  s_axis   in         s_axis_tvalid/tready        load or compute command word
//  m_axis   out        m_axis_tvalid/tready        one result element, tlast on the final one
//  cfg      in         cfg_valid/cfg_ready         active matrix size (always ready)
//
// A compute word runs a microcoded loop on the single shared multiply-accumulate
// path that follows the registered RAM read: add and subtract go once through
// read, compute, accumulate and emit per result element; multiply repeats read,
// multiply and accumulate for each of the j-i+1 terms of element (i,j), then emits.
// Reset clears the per-entry valid bits of both stores at once, so every
// element reads as zero until it is loaded; there is no clearing pass.
// The emit step stalls while the output register holds a word not yet taken;
// the final result may wait there while the next command word is accepted.
module packed_upper_triangular_matrix_ops #(
  parameter int unsigned MAX_DIM = putm_pkg::MAX_DIM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: operation[2:0], row[6:3], col[10:7], value[42:11], zero pad.
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: out_row[3:0], out_col[7:4], out_value[39:8].
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);

  localparam int unsigned DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] MaxDimL = 4'(MAX_DIM);

  // Packed column-major place of element (r,c), both 1-based.
  function automatic logic [IDX_W-1:0] tri_idx(logic [3:0] r, logic [3:0] c);
    logic [7:0] cc;
    logic [7:0] t;
    cc = {4'b0, c};
    t = ((cc * (cc - 8'd1)) >> 1) + {4'b0, r} - 8'd1;
    return t[IDX_W-1:0];
  endfunction

  putm_pkg::ctrl_t   cw;
  putm_pkg::status_t st;

  // Input word fields.
  putm_pkg::op_e in_op;
  logic [3:0]    in_row, in_col;
  logic [31:0]   in_value;
  assign in_op    = putm_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign in_row   = s_axis_tdata_i[6:3];
  assign in_col   = s_axis_tdata_i[10:7];
  assign in_value = s_axis_tdata_i[42:11];

  logic in_fire, is_compute, pos_ok, we_a, we_b;
  assign s_axis_tready_o = cw.in_rdy;
  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_compute = (in_op == putm_pkg::OP_ADD) || (in_op == putm_pkg::OP_SUB) ||
                      (in_op == putm_pkg::OP_MUL);
  assign pos_ok = (in_row != 4'd0) && (in_col != 4'd0) && (in_row <= MaxDimL) &&
                  (in_col <= MaxDimL) && (in_row <= in_col);
  assign we_a = in_fire && pos_ok && (in_op == putm_pkg::OP_LOAD_A);
  assign we_b = in_fire && pos_ok && (in_op == putm_pkg::OP_LOAD_B);

  // Configuration register and the clamped active size.
  logic [3:0] size_q, n_c;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end
  assign n_c = (size_q == 4'd0) ? 4'd1 : ((size_q > MaxDimL) ? MaxDimL : size_q);

  // Loop indices and the captured operation.
  putm_pkg::op_e op_q;
  logic [3:0]    i_q, j_q, k_q;
  logic          is_mul, last_c, emit_fire;
  assign is_mul    = (op_q == putm_pkg::OP_MUL);
  assign last_c    = (i_q == n_c) && (j_q == n_c);

  // Stores with reset-cleared valid bits; an unwritten entry reads as zero.
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]      ram_a, ram_b, opa, opb;
  logic [DEPTH-1:0] vld_a_q, vld_b_q;
  logic             rvld_a_q, rvld_b_q;

  assign waddr   = tri_idx(in_row, in_col);
  assign raddr_a = is_mul ? tri_idx(i_q, k_q) : tri_idx(i_q, j_q);
  assign raddr_b = is_mul ? tri_idx(k_q, j_q) : tri_idx(i_q, j_q);

  putm_ram #(.WIDTH(32), .DEPTH(DEPTH), .ADDR_W(IDX_W)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .re_i    (cw.rd),
    .raddr_i (raddr_a),
    .rdata_o (ram_a)
  );

  putm_ram #(.WIDTH(32), .DEPTH(DEPTH), .ADDR_W(IDX_W)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .re_i    (cw.rd),
    .raddr_i (raddr_b),
    .rdata_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= '0;
      vld_b_q  <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (we_a) begin
        vld_a_q[waddr] <= 1'b1;
      end
      if (we_b) begin
        vld_b_q[waddr] <= 1'b1;
      end
      if (cw.rd) begin
        rvld_a_q <= vld_a_q[raddr_a];
        rvld_b_q <= vld_b_q[raddr_b];
      end
    end
  end

  assign opa = rvld_a_q ? ram_a : 32'd0;
  assign opb = rvld_b_q ? ram_b : 32'd0;

  // Datapath: term register, accumulator, output register.
  logic [31:0] term_q, acc_q, prod;
  logic        m_valid_q, m_last_q;
  logic [39:0] m_data_q;

  assign prod = opa * opb;
  assign st.cmd_go     = in_fire && is_compute;
  assign st.inner_more = is_mul && (k_q != j_q);
  assign st.slot_free  = !m_valid_q || m_axis_tready_i;
  assign st.last       = last_c;
  assign emit_fire     = cw.emit && st.slot_free;

  always_ff @(posedge clk_i) begin
    if (cw.mul) begin
      unique case (op_q)
        putm_pkg::OP_MUL: term_q <= prod;
        putm_pkg::OP_SUB: term_q <= opa - opb;
        default:          term_q <= opa + opb;
      endcase
    end
    if (emit_fire) begin
      m_data_q <= {acc_q, j_q, i_q};
      m_last_q <= last_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= putm_pkg::OP_ADD;
      i_q   <= 4'd1;
      j_q   <= 4'd1;
      k_q   <= 4'd1;
      acc_q <= 32'd0;
    end else if (st.cmd_go) begin
      op_q  <= in_op;
      i_q   <= 4'd1;
      j_q   <= 4'd1;
      k_q   <= 4'd1;
      acc_q <= 32'd0;
    end else if (cw.acc) begin
      acc_q <= acc_q + term_q;
      if (st.inner_more) begin
        k_q <= k_q + 4'd1;
      end
    end else if (emit_fire) begin
      acc_q <= 32'd0;
      if (j_q == n_c) begin
        i_q <= i_q + 4'd1;
        j_q <= i_q + 4'd1;
        k_q <= i_q + 4'd1;
      end else begin
        j_q <= j_q + 4'd1;
        k_q <= i_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  putm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cw_o   (cw)
  );

`ifndef SYNTHESIS
  // A result never lies below the diagonal.
  a_upper_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:4] >= m_axis_tdata_o[3:0]))
    else $error("result element below the diagonal");

  // A compute word closes the input until its run is finished.
  a_compute_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.cmd_go |=> !s_axis_tready_o)
    else $error("input reopened right after a compute word");

  // Emitting the final element returns the sequencer to the idle step.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && last_c) |=> s_axis_tready_o)
    else $error("sequencer did not return to idle after the final element");
`endif

endmodule

// ===== verif/tb_packed_upper_triangular_matrix_ops.sv =====
// Self-checking testbench for the packed upper-triangular matrix add, subtract and multiply unit.
module tb_packed_upper_triangular_matrix_ops;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM       = putm_pkg::MAX_DIM_DEF;
  localparam int unsigned TRI_DEPTH     = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_WAIT      = 13;
  localparam int unsigned RANDOM_WORDS  = 256;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned MAX_PRINTED   = 60;
  localparam logic [3:0]  SIZE_AT_RESET = 4'd8;
  // Operation codes that the unit has no meaning for.
  localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;

  // One result element as the output channel carries it.
  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic        last;
  } elem_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic [47:0] s_axis_tdata_i  = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [3:0]  cfg_data_i      = '0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;

  // Shadow copy of the unit: both packed stores and the size register.
  logic [31:0] a_elems [TRI_DEPTH];
  logic [31:0] b_elems [TRI_DEPTH];
  logic [3:0]  size_shadow;
  elem_t       pending_results [$];

  int unsigned src_wait_max  = 0;
  int unsigned sink_wait_max = 0;
  int unsigned sink_wait     = 0;
  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int unsigned load_count    = 0;
  int unsigned compute_count = 0;
  int unsigned ignored_count = 0;
  int unsigned result_count  = 0;
  int unsigned size_writes   = 0;
  elem_t       seen_elem;
  elem_t       want_elem;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packed_upper_triangular_matrix_ops #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o)
  );

  function automatic int unsigned draw_wait(input int unsigned max_wait);
    if (max_wait == 0) begin
      return 0;
    end
    return $urandom_range(max_wait, 0);
  endfunction

  // Column-major packed position of an upper element, 1-based row and column.
  function automatic int unsigned tri_pos(input int unsigned r, input int unsigned c);
    return c * (c - 1) / 2 + r - 1;
  endfunction

  // The size register is clamped into 1..MAX_DIM when a compute word runs.
  function automatic int unsigned active_dim();
    if (size_shadow < 1) begin
      return 1;
    end
    if (size_shadow > MAX_DIM) begin
      return MAX_DIM;
    end
    return 32'(size_shadow);
  endfunction

  function automatic logic [31:0] random_value();
    if ($urandom_range(3, 0) != 0) begin
      return $urandom();
    end
    case ($urandom_range(4, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Applies one accepted command word to the shadow state and queues the
  // result elements that it should produce.
  task automatic predict_matrix_op(input logic [2:0] op, input logic [3:0] r,
                                   input logic [3:0] c, input logic [31:0] v);
    int unsigned n;
    int unsigned total;
    int unsigned count;
    logic [31:0] acc;
    logic [31:0] term;
    elem_t       elem;
    case (op) inside
      putm_pkg::OP_LOAD_A, putm_pkg::OP_LOAD_B: begin
        // Positions outside the store and the zero lower part are dropped.
        if (r >= 1 && c >= 1 && r <= MAX_DIM && c <= MAX_DIM && r <= c) begin
          if (op == putm_pkg::OP_LOAD_A) begin
            a_elems[tri_pos(r, c)] = v;
          end else begin
            b_elems[tri_pos(r, c)] = v;
          end
          load_count++;
        end else begin
          ignored_count++;
        end
      end
      putm_pkg::OP_ADD, putm_pkg::OP_SUB, putm_pkg::OP_MUL: begin
        n = active_dim();
        total = n * (n + 1) / 2;
        count = 0;
        compute_count++;
        for (int i = 1; i <= n; i++) begin
          for (int j = i; j <= n; j++) begin
            if (op == putm_pkg::OP_ADD) begin
              acc = a_elems[tri_pos(i, j)] + b_elems[tri_pos(i, j)];
            end else if (op == putm_pkg::OP_SUB) begin
              acc = a_elems[tri_pos(i, j)] - b_elems[tri_pos(i, j)];
            end else begin
              acc = '0;
              for (int k = i; k <= j; k++) begin
                term = a_elems[tri_pos(i, k)] * b_elems[tri_pos(k, j)];
                acc = acc + term;
              end
            end
            count++;
            elem.row   = 4'(i);
            elem.col   = 4'(j);
            elem.value = acc;
            elem.last  = (count == total);
            pending_results.push_back(elem);
          end
        end
      end
      default: begin
        ignored_count++;
      end
    endcase
  endtask

  // Presents one command word after a random gap and holds it until taken.
  task automatic send_word(input logic [2:0] op, input logic [3:0] r,
                           input logic [3:0] c, input logic [31:0] v);
    int unsigned gap;
    gap = draw_wait(src_wait_max);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {5'b0, v, c, r, op};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_matrix_op(op, r, c, v);
  endtask

  // Stops the input stream and lets every queued result drain; loads leave
  // no trace in the queue, so a settling wait follows to cover one still in flight.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_matrix_size(input logic [3:0] n);
    wait_idle();
    cfg_data_i  <= n;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_shadow = n;
    size_writes++;
  endtask

  // Mostly in-range loads with random content, some stray positions and
  // unknown codes, and now and then a compute word to read the stores back.
  task automatic send_random_word(output bit counts);
    int unsigned pick;
    int unsigned n;
    logic [2:0]  op;
    logic [3:0]  r;
    logic [3:0]  c;
    pick = $urandom_range(99, 0);
    n = active_dim();
    op = $urandom_range(1, 0) ? putm_pkg::OP_LOAD_B : putm_pkg::OP_LOAD_A;
    r = 4'($urandom_range(15, 0));
    c = 4'($urandom_range(15, 0));
    counts = 1'b1;
    if (pick < 62) begin
      c = ($urandom_range(3, 0) != 0) ? 4'($urandom_range(n, 1))
                                       : 4'($urandom_range(MAX_DIM, 1));
      r = 4'($urandom_range(c, 1));
    end else if (pick < 74) begin
      counts = (r >= 1 && c >= 1 && r <= MAX_DIM && c <= MAX_DIM && r <= c);
    end else if (pick < 80) begin
      op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      counts = 1'b0;
    end else if (pick < 86) begin
      op = putm_pkg::OP_ADD;
    end else if (pick < 92) begin
      op = putm_pkg::OP_SUB;
    end else begin
      op = putm_pkg::OP_MUL;
    end
    send_word(op, r, c, random_value());
  endtask

  // Freshly reset stores are all zero and the size starts at its maximum.
  task automatic test_reset_state();
    src_wait_max  = 0;
    sink_wait_max = 0;
    send_word(putm_pkg::OP_ADD, 4'd1, 4'd1, 32'h0);
    send_word(putm_pkg::OP_SUB, 4'd1, 4'd1, 32'h0);
    send_word(putm_pkg::OP_MUL, 4'd1, 4'd1, 32'h0);
  endtask

  // Value extremes with wrap-around in every operation, plus words that the
  // unit must drop: lower elements, positions off the store, unknown codes.
  task automatic test_directed_loads();
    src_wait_max  = MAX_WAIT;
    sink_wait_max = MAX_WAIT;
    send_word(putm_pkg::OP_LOAD_A, 4'd1, 4'd1, 32'h7FFF_FFFF);
    send_word(putm_pkg::OP_LOAD_B, 4'd1, 4'd1, 32'h0000_0001);
    send_word(putm_pkg::OP_LOAD_A, 4'd1, 4'd2, 32'h8000_0000);
    send_word(putm_pkg::OP_LOAD_B, 4'd1, 4'd2, 32'h0000_0001);
    send_word(putm_pkg::OP_LOAD_A, 4'd8, 4'd8, 32'hFFFF_FFFF);
    send_word(putm_pkg::OP_LOAD_B, 4'd8, 4'd8, 32'hFFFF_FFFF);
    send_word(putm_pkg::OP_LOAD_A, 4'd2, 4'd2, 32'h0001_0000);
    send_word(putm_pkg::OP_LOAD_B, 4'd2, 4'd8, 32'h0001_0000);
    send_word(putm_pkg::OP_LOAD_A, 4'd3, 4'd2, 32'hDEAD_BEEF);
    send_word(putm_pkg::OP_LOAD_B, 4'd0, 4'd4, 32'h1234_5678);
    send_word(putm_pkg::OP_LOAD_A, 4'd4, 4'd9, 32'h5555_AAAA);
    send_word(putm_pkg::OP_LOAD_B, 4'd15, 4'd15, 32'hAAAA_5555);
    send_word(OP_FIRST_UNUSED, 4'd1, 4'd1, 32'hFFFF_FFFF);
    send_word(OP_LAST_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_word(putm_pkg::OP_ADD, 4'd0, 4'd0, 32'h0);
    send_word(putm_pkg::OP_SUB, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_word(putm_pkg::OP_MUL, 4'd0, 4'd0, 32'h0);
  endtask

  // Smallest and largest sizes, and the out-of-range codes on both sides.
  task automatic test_size_limits();
    src_wait_max  = MAX_WAIT;
    sink_wait_max = 0;
    set_matrix_size(4'd1);
    send_word(putm_pkg::OP_MUL, 4'd1, 4'd1, 32'h0);
    set_matrix_size(4'd0);
    send_word(putm_pkg::OP_ADD, 4'd1, 4'd1, 32'h0);
    set_matrix_size(4'd15);
    send_word(putm_pkg::OP_MUL, 4'd1, 4'd1, 32'h0);
    set_matrix_size(4'd8);
    send_word(putm_pkg::OP_SUB, 4'd1, 4'd1, 32'h0);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    bit          counts;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Small sizes keep the multiply loop short; a few phases go large.
      case ($urandom_range(4, 0))
        0:       set_matrix_size(4'($urandom_range(15, 0)));
        1:       set_matrix_size(4'($urandom_range(8, 5)));
        default: set_matrix_size(4'($urandom_range(4, 1)));
      endcase
      src_wait_max  = (phase % 4 == 1 || phase % 4 == 3) ? MAX_WAIT : 0;
      sink_wait_max = (phase % 4 >= 2) ? MAX_WAIT : 0;
      sent = 0;
      while (sent < RANDOM_WORDS / RANDOM_PHASES) begin
        send_random_word(counts);
        if (counts) begin
          sent++;
        end
      end
      send_word(putm_pkg::OP_MUL, 4'd1, 4'd1, 32'h0);
    end
  endtask

  // Result checker and receiver: every accepted word is matched against the
  // oldest expected element, then a fresh stall length is drawn.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_elem.row   = m_axis_tdata_o[3:0];
      seen_elem.col   = m_axis_tdata_o[7:4];
      seen_elem.value = m_axis_tdata_o[39:8];
      seen_elem.last  = m_axis_tlast_o;
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word (%0d,%0d) %h with nothing expected",
                                  seen_elem.row, seen_elem.col, seen_elem.value));
      end else begin
        want_elem = pending_results.pop_front();
        if (seen_elem.row != want_elem.row) begin
          report_mismatch($sformatf("row got %0d want %0d",
                                    seen_elem.row, want_elem.row));
        end
        if (seen_elem.col != want_elem.col) begin
          report_mismatch($sformatf("col got %0d want %0d",
                                    seen_elem.col, want_elem.col));
        end
        if (seen_elem.value != want_elem.value) begin
          report_mismatch($sformatf("value at (%0d,%0d) got %h want %h",
                                    want_elem.row, want_elem.col,
                                    seen_elem.value, want_elem.value));
        end
        if (seen_elem.last != want_elem.last) begin
          report_mismatch($sformatf("last at (%0d,%0d) got %0b want %0b",
                                    want_elem.row, want_elem.col,
                                    seen_elem.last, want_elem.last));
        end
      end
      sink_wait = draw_wait(sink_wait_max);
      if (sink_wait != 0) begin
        m_axis_tready_i <= 1'b0;
      end
    end else if (!m_axis_tready_i) begin
      if (sink_wait != 0) begin
        sink_wait--;
      end
      if (sink_wait == 0) begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < TRI_DEPTH; i++) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
    end
    size_shadow = SIZE_AT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_loads();
    test_size_limits();
    test_random_traffic();
    wait_idle();

    $display("Covered %0d loads, %0d compute words and %0d dropped words, %0d size writes,",
             load_count, compute_count, ignored_count, size_writes);
    $display("and checked %0d result words with random stalls on both channels.",
             result_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/putm_pkg.sv
rtl/putm_ram.sv
rtl/putm_seq.sv
rtl/packed_upper_triangular_matrix_ops.sv
verif/tb_packed_upper_triangular_matrix_ops.sv
